// ----- hw/rtl/lru_page_replacement_unit_macros.svh -----
// assertion helpers for the lru page replacement unit
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition that holds at every edge out of reset
`define LPR_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lpr assertion failed");
// condition that must hold in the cycle after a trigger
`define LPR_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("lpr assertion failed");
`else
`define LPR_ASSERT(label, clk, rstn, prop)
`define LPR_ASSERT_NEXT(label, clk, rstn, pre, post)
`endif

`endif

// ----- hw/rtl/lpr_pkg.sv -----
package lpr_pkg;

  typedef enum logic [0:0] {
    ST_EMPTY,
    ST_HOLD
  } lpr_state_e;

  typedef struct packed {
    logic commit;
  } lpr_cmd_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ACTIVE_FRAMES = 3'd0;

  localparam logic [3:0]  ACTIVE_FRAMES_RESET = 4'd3;
  localparam logic [15:0] FAULT_MAX           = 16'hFFFF;

endpackage

// ----- hw/rtl/lpr_ctrl.sv -----
module lpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lpr_pkg::lpr_cmd_t cmd_o
);

  lpr_pkg::lpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  // output register frees up in the same cycle it is taken
  always_comb begin
    out_valid_o   = (state_q == lpr_pkg::ST_HOLD);
    in_ready_o    = (state_q == lpr_pkg::ST_EMPTY) || out_ready_i;
    cmd_o.commit  = in_valid_i && in_ready_o;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpr_pkg::ST_EMPTY: begin
        if (in_valid_i) state_d = lpr_pkg::ST_HOLD;
      end
      lpr_pkg::ST_HOLD: begin
        if (out_ready_i && !in_valid_i) state_d = lpr_pkg::ST_EMPTY;
      end
      default: state_d = lpr_pkg::ST_EMPTY;
    endcase
  end

endmodule

// ----- hw/rtl/lpr_datapath.sv -----
`include "lru_page_replacement_unit_macros.svh"

module lpr_datapath #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpr_pkg::lpr_cmd_t cmd_i,
  input  logic [3:0]        active_frames_i,
  input  logic [15:0]       page_number_i,
  input  logic              last_reference_i,
  output logic              hit_o,
  output logic              evicted_valid_o,
  output logic [15:0]       evicted_page_o,
  output logic [15:0]       fault_count_o
);

  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;

  logic [PAGE_BITS-1:0] frames_q [FRAMES];
  logic [PAGE_BITS-1:0] frames_d [FRAMES];
  logic [PAGE_BITS-1:0] frames_up [FRAMES];
  logic [CNT_W-1:0]     filled_q, filled_d;
  logic [15:0]          faults_q, faults_d;

  logic                 hit_q, ev_valid_q;
  logic [15:0]          ev_page_q, fault_count_q;

  logic [PAGE_BITS-1:0] page;
  logic [CMP_W-1:0]     af_ext, eff_ext;
  logic [CNT_W-1:0]     eff_n, filled;
  logic [FRAMES-1:0]    match;
  logic                 page_hit, full;
  logic [IDX_W-1:0]     hit_idx;
  logic [CNT_W-1:0]     shift_from, top;
  logic [15:0]          faults_inc;
  logic [15:0]          ev_page;
  logic                 fault_step;

  assign page = PAGE_BITS'(page_number_i);

  // frame count clamped to 1..FRAMES
  always_comb begin
    af_ext = CMP_W'(active_frames_i);
    if (af_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (af_ext > CMP_W'(FRAMES)) begin
      eff_ext = CMP_W'(FRAMES);
    end else begin
      eff_ext = af_ext;
    end
    eff_n  = CNT_W'(eff_ext);
    filled = (filled_q < eff_n) ? filled_q : eff_n;
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = (CNT_W'(i) < filled) && (frames_q[i] == page);
    end
  end

  // lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end

  always_comb begin
    page_hit = |match;
    full     = (filled == eff_n);
    if (page_hit) begin
      shift_from = CNT_W'(hit_idx);
    end else if (full) begin
      shift_from = '0;
    end else begin
      shift_from = filled;
    end
    top = (page_hit || full) ? (filled - CNT_W'(1)) : filled;
  end

  // each slot below the last sees its upper neighbour for the shift towards slot 0
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    if (g == FRAMES - 1) begin : g_last
      assign frames_up[g] = frames_q[g];
    end else begin : g_mid
      assign frames_up[g] = frames_q[g+1];
    end

    always_comb begin
      frames_d[g] = frames_q[g];
      if ((CNT_W'(g) >= shift_from) && (CNT_W'(g) < top)) begin
        frames_d[g] = frames_up[g];
      end else if (CNT_W'(g) == top) begin
        frames_d[g] = page;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) frames_q[g] <= frames_d[g];
    end
  end

  always_comb begin
    faults_inc = (faults_q == lpr_pkg::FAULT_MAX) ? faults_q : (faults_q + 16'd1);
    faults_d   = page_hit ? faults_q : faults_inc;
    filled_d   = (!page_hit && !full) ? (filled + CNT_W'(1)) : filled;
    ev_page    = (!page_hit && full) ? 16'(frames_q[0]) : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q   <= '0;
      faults_q   <= '0;
      hit_q      <= 1'b0;
      ev_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      filled_q   <= last_reference_i ? '0 : filled_d;
      faults_q   <= last_reference_i ? '0 : faults_d;
      hit_q      <= page_hit;
      ev_valid_q <= !page_hit && full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ev_page_q     <= ev_page;
      fault_count_q <= faults_d;
    end
  end

  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_count_q;

  assign fault_step = cmd_i.commit && !page_hit && !last_reference_i &&
                      (faults_q != lpr_pkg::FAULT_MAX);

  `LPR_ASSERT(a_filled_bound, clk_i, rst_ni, filled_q <= CNT_W'(FRAMES))
  `LPR_ASSERT(a_hit_no_evict, clk_i, rst_ni, !(hit_q && ev_valid_q))
  `LPR_ASSERT_NEXT(a_fault_step, clk_i, rst_ni, fault_step, faults_q == $past(faults_q) + 16'd1)

endmodule

// ----- hw/rtl/lru_page_replacement_unit.sv -----
// lru page replacement unit
// input channel: in_valid_i/in_ready_o with page_number_i and last_reference_i,
// one page reference per word. output channel: out_valid_o/out_ready_i with
// hit_o, evicted_valid_o, evicted_page_o and fault_count_o, one word per
// reference. the reference is compared against every frame and the recency
// stack shifts in the same cycle, so the result appears in the cycle after
// acceptance, and a new reference is taken every cycle while the receiver
// takes each result; the compare and shift select over the frame row are combinational.
// the output register frees up in the cycle its word is taken, so while the
// receiver stalls one result waits and no further reference is accepted.
// last_reference_i clears the resident frames and the fault count once its
// result is formed. active_frames (byte address 0 of the apb port, reset 3)
// sets the frames in use, 0 acting as 1 and values above FRAMES as FRAMES;
// write it only while idle. reset empties the stack, zeroes the fault count
// and drops any pending result; no clearing pass is needed.
module lru_page_replacement_unit #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    page_number_i,
  input  logic                           last_reference_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic                           evicted_valid_o,
  output logic [15:0]                    evicted_page_o,
  output logic [15:0]                    fault_count_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [3:0]        active_frames_q, active_frames_d;
  logic              cfg_wr;
  lpr_pkg::lpr_cmd_t cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    active_frames_d = active_frames_q;
    if (cfg_wr && (paddr == lpr_pkg::ADDR_ACTIVE_FRAMES)) active_frames_d = pwdata[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_frames_q <= lpr_pkg::ACTIVE_FRAMES_RESET;
    end else begin
      active_frames_q <= active_frames_d;
    end
  end

  assign prdata = (paddr == lpr_pkg::ADDR_ACTIVE_FRAMES) ? {28'd0, active_frames_q} : 32'd0;

  lpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .active_frames_i  (active_frames_q),
    .page_number_i    (page_number_i),
    .last_reference_i (last_reference_i),
    .hit_o            (hit_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_page_o   (evicted_page_o),
    .fault_count_o    (fault_count_o)
  );

endmodule
